/* design/lc_period_meter_macros.svh */
// Assertion macros shared by the LC period meter design files.
// Clocked on i_clk; LCPM_ASSERT is disabled while i_rst_n is low, LCPM_ASSERT_ALWAYS is not.
`ifndef LC_PERIOD_METER_MACROS_SVH
`define LC_PERIOD_METER_MACROS_SVH

`ifndef ASSERT_OFF
// checked property, masked during reset
`define LCPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// checked property, also evaluated during reset
`define LCPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define LCPM_ASSERT(lbl, prop, msg)
`define LCPM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* design/lcpm_pkg.sv */
// Shared types and constants for the LC period meter.
// No dependencies; imported by lcpm_serial_mul, lc_period_meter and the testbench.
package lcpm_pkg;

    localparam int MUL_W  = 32;
    localparam int STEP_W = 6;
    localparam int TIME_W = 16;
    localparam int SCL_W  = 40;   // product >> 24

    localparam logic [STEP_W-1:0] SQR_STEPS = STEP_W'(TIME_W);
    localparam logic [STEP_W-1:0] SCL_STEPS = STEP_W'(MUL_W);

    localparam logic [SCL_W-1:0] WINDOW_MAX = SCL_W'(256000);  // 1000.0 in Q32.8
    localparam logic [MUL_W-1:0] CAP_SCALE_RST = 32'd10876446;
    localparam logic [MUL_W-1:0] IND_SCALE_RST = 32'd10876446;

    typedef enum logic [1:0] {
        REQ_OVF  = 2'd0,
        REQ_CAP  = 2'd1,
        REQ_MODE = 2'd2,
        REQ_READ = 2'd3
    } t_req;

    typedef enum logic {
        CFG_CAP_SCALE = 1'b0,
        CFG_IND_SCALE = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQR,
        ST_SCL,
        ST_SUB,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_mul_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mul_stat;

endpackage

/* design/lcpm_serial_mul.sv */
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on lcpm_pkg and lc_period_meter_macros.svh.
`include "lc_period_meter_macros.svh"

module lcpm_serial_mul
    import lcpm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mul_ctrl        i_ctrl,
    input  logic [MUL_W-1:0] i_a,
    input  logic [MUL_W-1:0] i_b,
    output t_mul_stat        o_stat,
    output logic [MUL_W-1:0] o_hi,
    output logic [MUL_W-1:0] o_lo
);

    logic [MUL_W-1:0]  r_a, r_hi, r_lo;
    logic [MUL_W-1:0]  n_hi, n_lo;
    logic [MUL_W:0]    n_sum;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy, r_done, n_done;

    // add multiplicand on the current multiplier bit, then shift right
    always_comb begin
        n_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
        n_hi   = n_sum[MUL_W:1];
        n_lo   = {n_sum[0], r_lo[MUL_W-1:1]};
        n_done = r_busy && (r_cnt == STEP_W'(1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctrl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_ctrl.steps;
        end else begin
            r_done <= n_done;
            if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (n_done) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.start) begin
            r_a  <= i_a;
            r_hi <= '0;
            r_lo <= i_b;
        end else if (r_busy) begin
            r_hi <= n_hi;
            r_lo <= n_lo;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_hi        = r_hi;
    assign o_lo        = r_lo;

    `LCPM_ASSERT(a_no_restart, i_ctrl.start |-> !r_busy, "start while multiplier busy")
    `LCPM_ASSERT(a_done_after_busy, r_done |-> $past(r_busy), "done without a run")
    `LCPM_ASSERT(a_done_pulse, r_done |=> !r_done, "done held for more than one cycle")

endmodule

/* design/lc_period_meter.sv */
// LC period meter top level: request decode, sequencer, result register.
// Depends on lcpm_pkg, lcpm_serial_mul and lc_period_meter_macros.svh.
//
//  channel   direction  handshake                    payload
//  in        sink       i_in_valid / o_in_ready      i_req_type, i_captured_time
//  out       source     o_out_valid / i_out_ready    o_reading, o_is_reference,
//                                                    o_meter_mode
//  cfg       sink       i_cfg_we (no wait)           i_cfg_idx, i_cfg_data
//
// Overflow, capture and mode transactions are handled on acceptance, without the multiplier.
// A read runs the square and then the scaling in the bit-serial multiplier,
// then the subtract and the result load.
// A finished result waits in the output register; new input is taken meanwhile,
// and a following read stalls only at its final load.
// Reset (synchronous, active low) clears mode, calibration and the period.
`include "lc_period_meter_macros.svh"

module lc_period_meter
    import lcpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_req_type,
    input  logic [TIME_W-1:0] i_captured_time,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MUL_W-1:0]  o_reading,
    output logic              o_is_reference,
    output logic              o_meter_mode,
    // configuration
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [MUL_W-1:0]  i_cfg_data
);

    t_state r_state, n_state;

    logic [MUL_W-1:0]  r_cap_scale, r_ind_scale;
    // Only the low 16 bits of the period reach the square, and those are
    // independent of the overflow count, so neither the count nor the upper
    // period bits are kept.
    logic [TIME_W-1:0] r_last_edge, r_period;
    logic              r_mode, r_calibrated;
    logic [MUL_W-1:0]  r_ref;
    logic [MUL_W-1:0]  r_factor;
    logic              r_is_ref;
    logic [SCL_W-1:0]  r_scaled;
    logic [SCL_W:0]    r_diff;    // top bit is the borrow
    logic              r_out_valid;
    logic [MUL_W-1:0]  r_reading;
    logic              r_out_ref, r_out_mode;

    logic              w_in_acc, w_read_acc, w_out_free, w_load_out;
    logic [MUL_W-1:0]  w_sat, w_meas, w_result;
    t_req              w_req;

    t_mul_ctrl         w_mul_ctrl;
    t_mul_stat         w_mul_stat;
    logic [MUL_W-1:0]  w_mul_a, w_mul_b, w_mul_hi, w_mul_lo;

    assign w_req      = t_req'(i_req_type);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_read_acc = w_in_acc && (w_req == REQ_READ);
    assign w_out_free = !r_out_valid || i_out_ready;

    lcpm_serial_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_mul_ctrl),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_stat  (w_mul_stat),
        .o_hi    (w_mul_hi),
        .o_lo    (w_mul_lo)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_read_acc)        n_state = ST_SQR;
            ST_SQR:  if (w_mul_stat.done)   n_state = ST_SCL;
            ST_SCL:  if (w_mul_stat.done)   n_state = ST_SUB;
            ST_SUB:                         n_state = ST_FIN;
            ST_FIN:  if (w_out_free)        n_state = ST_IDLE;
            default:                        n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_ready       = 1'b0;
        w_mul_ctrl.start = 1'b0;
        w_mul_ctrl.steps = SQR_STEPS;
        w_mul_a          = {{(MUL_W-TIME_W){1'b0}}, r_period};
        w_mul_b          = {{(MUL_W-TIME_W){1'b0}}, r_period};
        w_load_out       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready       = 1'b1;
                w_mul_ctrl.start = w_read_acc;
            end
            ST_SQR: begin
                // square sits in {hi, lo upper half} after a 16-step run
                w_mul_ctrl.start = w_mul_stat.done;
                w_mul_ctrl.steps = SCL_STEPS;
                w_mul_a          = r_factor;
                w_mul_b          = {w_mul_hi[TIME_W-1:0], w_mul_lo[MUL_W-1:TIME_W]};
            end
            ST_FIN: begin
                w_load_out = w_out_free;
            end
            default: begin
            end
        endcase
    end

    // result formatting: saturate the reference, window the measurement
    always_comb begin
        w_sat  = (|r_scaled[SCL_W-1:MUL_W]) ? '1 : r_scaled[MUL_W-1:0];
        w_meas = (r_diff[SCL_W] || (r_diff[SCL_W-1:0] > WINDOW_MAX)) ? '0
                                                                    : r_diff[MUL_W-1:0];
        w_result = r_is_ref ? w_sat : w_meas;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mode       <= 1'b0;
            r_calibrated <= 1'b0;
            r_out_valid  <= 1'b0;
            r_cap_scale  <= CAP_SCALE_RST;
            r_ind_scale  <= IND_SCALE_RST;
            r_period     <= '0;
            r_last_edge  <= '0;
            r_ref        <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_CAP_SCALE: r_cap_scale <= i_cfg_data;
                    CFG_IND_SCALE: r_ind_scale <= i_cfg_data;
                    default:       r_cap_scale <= r_cap_scale;
                endcase
            end

            if (w_in_acc) begin
                case (w_req)
                    REQ_OVF: begin
                        // low period bits do not depend on the overflow count
                    end
                    REQ_CAP: begin
                        r_period    <= i_captured_time - r_last_edge;
                        r_last_edge <= i_captured_time;
                    end
                    REQ_MODE: begin
                        r_mode       <= ~r_mode;
                        r_calibrated <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end

            if (w_load_out) begin
                r_out_valid <= 1'b1;
                if (r_is_ref) begin
                    r_ref        <= w_sat;
                    r_calibrated <= 1'b1;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_read_acc) begin
            // factors swap between calibration and measurement
            r_is_ref <= !r_calibrated;
            if (!r_calibrated) begin
                r_factor <= r_mode ? r_ind_scale : r_cap_scale;
            end else begin
                r_factor <= r_mode ? r_cap_scale : r_ind_scale;
            end
        end
        if ((r_state == ST_SCL) && w_mul_stat.done) begin
            r_scaled <= {w_mul_hi, w_mul_lo[MUL_W-1:MUL_W-(SCL_W-MUL_W)]};
        end
        if (r_state == ST_SUB) begin
            r_diff <= {1'b0, r_scaled} - {{(SCL_W-MUL_W+1){1'b0}}, r_ref};
        end
        if (w_load_out) begin
            r_reading  <= w_result;
            r_out_ref  <= r_is_ref;
            r_out_mode <= r_mode;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reading      = r_reading;
    assign o_is_reference = r_out_ref;
    assign o_meter_mode   = r_out_mode;

    `LCPM_ASSERT(a_mul_running, (r_state == ST_SQR || r_state == ST_SCL) |-> (w_mul_stat.busy || w_mul_stat.done), "sequencer waits on an idle multiplier")
    `LCPM_ASSERT(a_mode_held, (r_state != ST_IDLE) |=> $stable(r_mode), "mode changed during a read")
    `LCPM_ASSERT(a_cal_with_ref, $rose(r_calibrated) |-> (r_out_valid && o_is_reference), "calibrated without a reference result")
    `LCPM_ASSERT_ALWAYS(a_rst_idle, !i_rst_n |=> (r_state == ST_IDLE && !r_out_valid), "reset did not clear control")

endmodule

/* verif/lc_period_meter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for lc_period_meter: directed corner cases, then random traffic.
// Depends on lcpm_pkg and the lc_period_meter RTL; uses a small scoreboard class.
module lc_period_meter_tb;
    import lcpm_pkg::*;

    localparam int HALF_PERIOD   = 6;          // 12 ns clock
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 1_000_000;  // far above the slowest legal run
    localparam int SETTLE_CYCLES = 8;          // non-read transactions are handled on acceptance
    localparam int TAIL_CYCLES   = 64;         // quiet tail after the last owed reading
    localparam int MAX_REPORTS   = 10;
    localparam int PHASE_ITEMS   = 400;

    // one result transaction, in port order
    typedef struct packed {
        logic [MUL_W-1:0] reading;
        logic             is_reference;
        logic             meter_mode;
    } t_reading;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the meter state, predicts each read and keeps
    // the readings still owed by the block, oldest first.
    // ------------------------------------------------------------------
    class lcpm_scoreboard;
        logic [MUL_W-1:0]  cap_scale;
        logic [MUL_W-1:0]  ind_scale;
        logic [31:0]       ovf_count;
        logic [TIME_W-1:0] edge_time;
        logic [31:0]       period;
        logic              mode;
        logic              calibrated;
        logic [MUL_W-1:0]  ref_level;
        t_reading          readings_due[$];
        int unsigned       errors;

        function new();
            cap_scale  = CAP_SCALE_RST;
            ind_scale  = IND_SCALE_RST;
            ovf_count  = '0;
            edge_time  = '0;
            period     = '0;
            mode       = 1'b0;
            calibrated = 1'b0;
            ref_level  = '0;
            errors     = 0;
        endfunction

        function void set_scale(t_cfg_idx idx, logic [MUL_W-1:0] value);
            if (idx == CFG_CAP_SCALE)
                cap_scale = value;
            else
                ind_scale = value;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction

        // low 16 bits of the period squared, times a Q0.32 factor, down to Q32.8
        function logic [SCL_W-1:0] scaled_square(logic [MUL_W-1:0] factor);
            logic [31:0] sq;
            logic [63:0] prod;
            sq   = {16'd0, period[15:0]} * {16'd0, period[15:0]};
            prod = 64'(sq) * 64'(factor);
            return prod[63:24];
        endfunction

        function void note_request(t_req req, logic [TIME_W-1:0] ct);
            logic [SCL_W-1:0] s;
            logic [SCL_W-1:0] diff;
            t_reading         want;
            case (req)
                REQ_OVF: ovf_count = ovf_count + 1;
                REQ_CAP: begin
                    period    = (ovf_count << 16) + {16'd0, ct} - {16'd0, edge_time};
                    edge_time = ct;
                    ovf_count = '0;
                end
                REQ_MODE: begin
                    mode       = ~mode;
                    calibrated = 1'b0;
                end
                REQ_READ: begin
                    if (!calibrated) begin
                        // reference: factors swapped against measurement
                        s          = scaled_square(mode ? ind_scale : cap_scale);
                        ref_level  = (s[SCL_W-1:MUL_W] != 0) ? '1 : s[MUL_W-1:0];
                        calibrated = 1'b1;
                        want       = '{ref_level, 1'b1, mode};
                    end else begin
                        s    = scaled_square(mode ? cap_scale : ind_scale);
                        diff = '0;
                        if (s >= {8'd0, ref_level}) begin
                            diff = s - {8'd0, ref_level};
                            if (diff > WINDOW_MAX)
                                diff = '0;
                        end
                        want = '{diff[MUL_W-1:0], 1'b0, mode};
                    end
                    readings_due.push_back(want);
                end
                default: ;
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%s", msg);
        endfunction

        function void check_reading(t_reading got);
            t_reading want;
            if (readings_due.size() == 0) begin
                flag($sformatf("unexpected reading %0d ref %0b mode %0b",
                               got.reading, got.is_reference, got.meter_mode));
                return;
            end
            want = readings_due.pop_front();
            if (got.reading !== want.reading || got.is_reference !== want.is_reference ||
                got.meter_mode !== want.meter_mode)
                flag($sformatf("reading exp %0d ref %0b mode %0b, got %0d ref %0b mode %0b",
                               want.reading, want.is_reference, want.meter_mode,
                               got.reading, got.is_reference, got.meter_mode));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_req_type      = REQ_OVF;
    logic [TIME_W-1:0] i_captured_time = '0;
    logic              o_out_valid;
    logic              i_out_ready     = 1'b0;
    logic [MUL_W-1:0]  o_reading;
    logic              o_is_reference;
    logic              o_meter_mode;
    logic              i_cfg_we        = 1'b0;
    logic              i_cfg_idx       = CFG_CAP_SCALE;
    logic [MUL_W-1:0]  i_cfg_data      = '0;

    always #(HALF_PERIOD) i_clk = ~i_clk;

    lc_period_meter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_req_type      (i_req_type),
        .i_captured_time (i_captured_time),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_reading       (o_reading),
        .o_is_reference  (o_is_reference),
        .o_meter_mode    (o_meter_mode),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data)
    );

    lcpm_scoreboard sb = new();

    // idle rates, in percent of cycles, changed per phase
    int unsigned       send_idle_pct = 13;
    int unsigned       recv_idle_pct = 63;
    // driver's own copy of the last capture time, so periods can be aimed
    logic [TIME_W-1:0] edge_at       = '0;
    logic [TIME_W-1:0] base_ticks    = 16'd1000;

    // Receiver back-pressure: one ready decision per clock.
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: both channels sampled on the same edge as the DUT sees them.
    // Results go first; a read accepted on this edge cannot finish on it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready)
                sb.check_reading('{o_reading, o_is_reference, o_meter_mode});
            if (i_in_valid && o_in_ready)
                sb.note_request(t_req'(i_req_type), i_captured_time);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("lc_period_meter: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // One request transaction. Valid is left high on return so back-to-back
    // transactions never lower and raise it in the same time step.
    task automatic send_item(t_req req, logic [TIME_W-1:0] ct);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= req;
        i_captured_time <= ct;
        if (req == REQ_CAP)
            edge_at = ct;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop sending and let every owed reading come out; sampled on the
    // falling edge, once the monitor has seen the last accepted transaction.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Both scale registers, written back to back on an idle block.
    task automatic set_scales(logic [MUL_W-1:0] cap, logic [MUL_W-1:0] ind);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CAP_SCALE;
        i_cfg_data <= cap;
        @(posedge i_clk);
        sb.set_scale(CFG_CAP_SCALE, cap);
        i_cfg_idx  <= CFG_IND_SCALE;
        i_cfg_data <= ind;
        @(posedge i_clk);
        sb.set_scale(CFG_IND_SCALE, ind);
        i_cfg_we   <= 1'b0;
    endtask

    // Random traffic. Mostly well-formed measure cycles (overflows, a capture
    // near the current base period, a read), sometimes preceded by a mode
    // press; the rest is noise of any request type. Halfway through, the
    // sender holds off until the block has nothing left to deliver.
    task automatic run_phase(int n_items);
        int sent;
        int jitter;
        int pick;
        bit held;
        sent = 0;
        held = 1'b0;
        while (sent < n_items) begin
            if (!held && sent >= n_items / 2) begin
                drain();
                held = 1'b1;
            end
            if ($urandom_range(99) < 75) begin
                if ($urandom_range(99) < 15) begin
                    send_item(REQ_MODE, 16'($urandom));
                    sent++;
                end
                if ($urandom_range(99) < 20) begin
                    pick = $urandom_range(99);
                    if (pick < 50)
                        base_ticks = 16'($urandom_range(0, 2000));
                    else if (pick < 75)
                        base_ticks = 16'($urandom_range(0, 40));
                    else
                        base_ticks = 16'($urandom);
                end
                repeat ($urandom_range(0, 3)) begin
                    send_item(REQ_OVF, 16'($urandom));
                    sent++;
                end
                jitter = int'($urandom_range(0, 127)) - 64;
                send_item(REQ_CAP, edge_at + base_ticks + 16'(jitter));
                send_item(REQ_READ, 16'($urandom));
                sent += 2;
            end else begin
                send_item(t_req'($urandom_range(0, 3)), 16'($urandom));
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed: reset scales ---
        send_item(REQ_READ, 16'h0000);   // zero period, reference of zero
        send_item(REQ_READ, 16'hFFFF);   // measure equals reference: zero difference
        send_item(REQ_OVF, 16'h0000);
        send_item(REQ_OVF, 16'hFFFF);
        send_item(REQ_CAP, 16'hFFFF);    // largest low period
        send_item(REQ_READ, 16'h0000);   // far above the window
        send_item(REQ_MODE, 16'h0000);   // inductance, calibration cleared
        send_item(REQ_READ, 16'h0000);   // inductance reference
        send_item(REQ_CAP, 16'h0000);    // capture wraps, period of one
        send_item(REQ_READ, 16'h0000);   // below the reference
        send_item(REQ_MODE, 16'h0000);

        // --- directed: full-scale factors, saturated reference ---
        set_scales('1, '1);
        send_item(REQ_CAP, 16'hFFFF);
        send_item(REQ_READ, 16'h0000);
        send_item(REQ_READ, 16'h0000);

        // --- directed: window edge; period 256 squared is 2^16 ---
        set_scales('0, 32'd65536000);
        send_item(REQ_MODE, 16'h0000);
        send_item(REQ_MODE, 16'h0000);   // capacitance again, uncalibrated
        send_item(REQ_CAP, 16'h00FF);    // 0x00FF - 0xFFFF = 256
        send_item(REQ_READ, 16'h0000);   // reference of zero
        send_item(REQ_READ, 16'h0000);   // exactly 1000.0, kept
        set_scales('0, 32'd65536256);
        send_item(REQ_READ, 16'h0000);   // one LSB above 1000.0, zeroed

        // --- random: busy sender, slow receiver ---
        set_scales(CAP_SCALE_RST, IND_SCALE_RST);
        run_phase(PHASE_ITEMS);

        // --- random: slow sender, busy receiver, extreme factors ---
        set_scales('1, '0);
        send_idle_pct = 63;
        recv_idle_pct = 13;
        run_phase(PHASE_ITEMS);

        // --- random: no idling, moderate factors ---
        set_scales(32'($urandom_range(0, 32'h0400_0000)), 32'($urandom_range(0, 32'h0400_0000)));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_phase(PHASE_ITEMS);

        // wind down: everything owed must arrive, then a quiet tail
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.flag("readings left outstanding at end of run");

        if (sb.errors == 0)
            $display("lc_period_meter: match");
        else
            $display("lc_period_meter: mismatch");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/lcpm_pkg.sv
design/lcpm_serial_mul.sv
design/lc_period_meter.sv
verif/lc_period_meter_tb.sv
